// ----- rtl/core/ipsp_pkg.sv -----
package ipsp_pkg;

    // Field widths of the request and result items
    localparam int unsigned AddrW   = 32;
    localparam int unsigned PrefixW = 6;
    localparam int unsigned CountW  = 7;
    localparam int unsigned HostsW  = 31;
    localparam int unsigned IndexW  = 6;

    localparam int unsigned DefMaxSubnets = 64;

    // Prefix limits
    localparam logic [PrefixW-1:0] PrefixMax      = 6'd32;
    localparam logic [PrefixW-1:0] PrefixHostsMax = 6'd30;

    // Packed stream widths
    localparam int unsigned InDataW  = 80;   // 76 bits of fields, zero filled
    localparam int unsigned OutDataW = 176;  // 172 bits of fields, zero filled

    // Per-request plan handed from the prefix pipeline to the row generator
    typedef struct packed {
        logic [AddrW-1:0]   start_net;
        logic [AddrW-1:0]   step;
        logic [AddrW-1:0]   mask;
        logic [PrefixW-1:0] fin;
        logic               have_hosts;
        logic [IndexW-1:0]  last_idx;
    } plan_t;

endpackage

// ----- rtl/core/ipsp_prefix.sv -----
module ipsp_prefix
    import ipsp_pkg::*;
#(
    parameter int unsigned MAX_SUBNETS = DefMaxSubnets
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [AddrW-1:0]    in_addr,
    input  logic [PrefixW-1:0]  in_prefix,
    input  logic [CountW-1:0]   in_count,
    input  logic [HostsW-1:0]   in_hosts,
    output logic                out_valid,
    input  logic                out_ready,
    output plan_t               out_plan
);

    localparam logic [CountW-1:0] MaxCnt   = CountW'(MAX_SUBNETS);
    localparam logic [IndexW-1:0] MaxCntM1 = IndexW'(MAX_SUBNETS - 1);

    // Netmask of a prefix, zero for /0
    function automatic logic [AddrW-1:0] mask_of(input logic [PrefixW-1:0] p);
        logic [AddrW-1:0] m;
        m = '0;
        if (p != '0) begin
            m = {AddrW{1'b1}} << (PrefixMax - p);
        end
        return m;
    endfunction

    // Bit length of a byte, 0..8
    function automatic logic [3:0] bitlen8(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            if (v[i]) n = 4'(i + 1);
        end
        return n;
    endfunction

    // Bit length of a 6-bit value, 0..6
    function automatic logic [2:0] bitlen6(input logic [5:0] v);
        logic [2:0] n;
        n = '0;
        for (int i = 0; i < 6; i++) begin
            if (v[i]) n = 3'(i + 1);
        end
        return n;
    endfunction

    // Stage handshake
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // Stage 1: saturate the request fields, hosts + 1 for the host search
    logic [AddrW-1:0]   s1_addr_reg;
    logic [PrefixW-1:0] s1_base_reg, s1_base_next;
    logic [IndexW-1:0]  s1_cm1_reg, s1_cm1_next;
    logic               s1_hnz_reg;
    logic [AddrW-1:0]   s1_hp1_reg;

    always_comb begin
        s1_base_next = (in_prefix > PrefixMax) ? PrefixMax : in_prefix;
        if (in_count == '0) begin
            s1_cm1_next = '0;
        end else if (in_count > MaxCnt) begin
            s1_cm1_next = MaxCntM1;
        end else begin
            s1_cm1_next = IndexW'(in_count - CountW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            s1_addr_reg <= in_addr;
            s1_base_reg <= s1_base_next;
            s1_cm1_reg  <= s1_cm1_next;
            s1_hnz_reg  <= (in_hosts != '0);
            s1_hp1_reg  <= {1'b0, in_hosts} + AddrW'(1);
        end
    end

    // Stage 2: base network, log2 of the count, per-byte bit lengths
    logic [AddrW-1:0]   s2_net_reg;
    logic [PrefixW-1:0] s2_base_reg;
    logic [IndexW-1:0]  s2_cm1_reg;
    logic               s2_hnz_reg;
    logic [2:0]         s2_k_reg;
    logic [3:0]         s2_gnz_reg;
    logic [3:0]         s2_glen_reg [4];

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            s2_net_reg  <= s1_addr_reg & mask_of(s1_base_reg);
            s2_base_reg <= s1_base_reg;
            s2_cm1_reg  <= s1_cm1_reg;
            s2_hnz_reg  <= s1_hnz_reg;
            s2_k_reg    <= bitlen6(s1_cm1_reg);
            for (int g = 0; g < 4; g++) begin
                s2_gnz_reg[g]  <= (s1_hp1_reg[8*g +: 8] != 8'h00);
                s2_glen_reg[g] <= bitlen8(s1_hp1_reg[8*g +: 8]);
            end
        end
    end

    // Stage 3: host prefix, subnet prefix, final prefix
    logic [PrefixW-1:0] hbits;
    logic [PrefixW-1:0] host_p;
    logic [PrefixW:0]   sub_p;
    logic [PrefixW:0]   fin_wide;
    logic [PrefixW-1:0] s3_fin_next;

    always_comb begin
        if (s2_gnz_reg[3]) begin
            hbits = 6'd24 + PrefixW'(s2_glen_reg[3]);
        end else if (s2_gnz_reg[2]) begin
            hbits = 6'd16 + PrefixW'(s2_glen_reg[2]);
        end else if (s2_gnz_reg[1]) begin
            hbits = 6'd8 + PrefixW'(s2_glen_reg[1]);
        end else begin
            hbits = PrefixW'(s2_glen_reg[0]);
        end
        host_p   = s2_hnz_reg ? (PrefixMax - hbits) : s2_base_reg;
        sub_p    = {1'b0, s2_base_reg} + (PrefixW + 1)'(s2_k_reg);
        fin_wide = ({1'b0, host_p} > sub_p) ? {1'b0, host_p} : sub_p;
        s3_fin_next = (fin_wide > {1'b0, PrefixMax}) ? PrefixMax : fin_wide[PrefixW-1:0];
    end

    logic [AddrW-1:0]   s3_net_reg;
    logic [IndexW-1:0]  s3_cm1_reg;
    logic [PrefixW-1:0] s3_fin_reg;

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            s3_net_reg <= s2_net_reg;
            s3_cm1_reg <= s2_cm1_reg;
            s3_fin_reg <= s3_fin_next;
        end
    end

    // Stage 4: mask, block step (zero for /0, wraps mod 2^32), hosts flag
    logic [AddrW:0] block_wide;
    plan_t          plan_next;
    plan_t          plan_reg;

    always_comb begin
        block_wide           = (AddrW + 1)'(1) << (PrefixMax - s3_fin_reg);
        plan_next.start_net  = s3_net_reg;
        plan_next.step       = block_wide[AddrW-1:0];
        plan_next.mask       = mask_of(s3_fin_reg);
        plan_next.fin        = s3_fin_reg;
        plan_next.have_hosts = (s3_fin_reg <= PrefixHostsMax);
        plan_next.last_idx   = s3_cm1_reg;
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            plan_reg <= plan_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_plan  = plan_reg;

endmodule

// ----- rtl/core/ipsp_rowgen.sv -----
module ipsp_rowgen
    import ipsp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  plan_t              in_plan,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [AddrW-1:0]   network_address,
    output logic [AddrW-1:0]   broadcast_address,
    output logic [AddrW-1:0]   first_host,
    output logic [AddrW-1:0]   last_host,
    output logic               hosts_present,
    output logic [PrefixW-1:0] final_prefix,
    output logic [AddrW-1:0]   final_mask,
    output logic [IndexW-1:0]  subnet_index,
    output logic               last_row
);

    logic              valid_reg;
    plan_t             plan_reg;
    logic [AddrW-1:0]  net_reg;
    logic [IndexW-1:0] idx_reg;
    logic              is_last;
    logic              row_done;

    assign is_last  = (idx_reg == plan_reg.last_idx);
    assign row_done = valid_reg && out_ready;
    assign in_ready = !valid_reg || (row_done && is_last);

    // Control: busy while rows of the current request remain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Row walk: load a new plan, or step to the next subnet
    always_ff @(posedge aclk) begin
        if (in_ready) begin
            plan_reg <= in_plan;
            net_reg  <= in_plan.start_net;
            idx_reg  <= '0;
        end else if (row_done) begin
            net_reg <= net_reg + plan_reg.step;
            idx_reg <= idx_reg + IndexW'(1);
        end
    end

    // Network is aligned to the block, so the host fields need no carry
    logic [AddrW-1:0] bcast;

    assign bcast             = net_reg | ~plan_reg.mask;
    assign out_valid         = valid_reg;
    assign network_address   = net_reg;
    assign broadcast_address = bcast;
    assign first_host        = plan_reg.have_hosts ? (net_reg | AddrW'(1)) : '0;
    assign last_host         = plan_reg.have_hosts ? (bcast & ~AddrW'(1)) : '0;
    assign hosts_present     = plan_reg.have_hosts;
    assign final_prefix      = plan_reg.fin;
    assign final_mask        = plan_reg.mask;
    assign subnet_index      = idx_reg;
    assign last_row          = is_last;

    // Row index never runs past the last row of the request
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (idx_reg <= plan_reg.last_idx))
        else $error("row index past last row");

    // A taken row that is not the last moves on by exactly one
    a_idx_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (row_done && !is_last) |=> (idx_reg == $past(idx_reg) + IndexW'(1)))
        else $error("row index did not advance");

    // Network stays aligned to the final block size
    a_net_align: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> ((net_reg & ~plan_reg.mask) == '0))
        else $error("network address not aligned");

    // A new plan is taken only when no rows of the old one remain
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_ready && valid_reg) |-> (row_done && is_last))
        else $error("request dropped before its last row");

endmodule

// ----- rtl/core/ipv4_subnet_planner_core.sv -----
// IPv4 subnet planner. Each request (address, base prefix, subnet count,
// host count) is turned into one row per subnet: network, broadcast, first
// and last host, the final prefix and its mask. A four-stage prefix pipeline
// works out the base network and the final prefix and can take a request
// every cycle unless the row generator behind it stalls; that generator
// emits one row per cycle while the output is ready. A request yields N
// rows, N being its subnet count after saturation (0 counts as 1, capped at
// MAX_SUBNETS), and the row generator takes the next request only as the
// last row of the current one is taken.
module ipv4_subnet_planner_core
    import ipsp_pkg::*;
#(
    parameter int unsigned MAX_SUBNETS = DefMaxSubnets
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // address[31:0], prefix_length[37:32], subnet_count[44:38],
    // host_count[75:45], zero fill above
    input  logic [InDataW-1:0]  s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // network_address[31:0], broadcast_address[63:32], first_host[95:64],
    // last_host[127:96], final_prefix[133:128], final_mask[165:134],
    // subnet_index[171:166], zero fill above
    output logic [OutDataW-1:0] m_tdata,
    // hosts_present
    output logic                m_tuser,
    // last_row
    output logic                m_tlast
);

    logic               plan_valid;
    logic               plan_ready;
    plan_t              plan;

    ipsp_prefix #(
        .MAX_SUBNETS(MAX_SUBNETS)
    ) u_prefix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_addr   (s_tdata[31:0]),
        .in_prefix (s_tdata[37:32]),
        .in_count  (s_tdata[44:38]),
        .in_hosts  (s_tdata[75:45]),
        .out_valid (plan_valid),
        .out_ready (plan_ready),
        .out_plan  (plan)
    );

    logic [AddrW-1:0]   net;
    logic [AddrW-1:0]   bcast;
    logic [AddrW-1:0]   first_h;
    logic [AddrW-1:0]   last_h;
    logic [PrefixW-1:0] fin;
    logic [AddrW-1:0]   fmask;
    logic [IndexW-1:0]  idx;

    ipsp_rowgen u_rowgen (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_valid          (plan_valid),
        .in_ready          (plan_ready),
        .in_plan           (plan),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .network_address   (net),
        .broadcast_address (bcast),
        .first_host        (first_h),
        .last_host         (last_h),
        .hosts_present     (m_tuser),
        .final_prefix      (fin),
        .final_mask        (fmask),
        .subnet_index      (idx),
        .last_row          (m_tlast)
    );

    // Pack the result row
    assign m_tdata = {4'h0, idx, fmask, fin, last_h, first_h, bcast, net};

endmodule
